/* rtl/core/rtab_pkg.sv */
`default_nettype none
package rtab_pkg;

  // Width of the network number and mask fields on the ports
  localparam int FIELD_W = 16;

  // Entries in the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Handshake between the job queue and the block generator
  typedef struct packed {
    logic valid;
    logic stall;
  } rtab_hs_t;

endpackage
`default_nettype wire

/* rtl/core/rtab_front.sv */
`default_nettype none
module rtab_front #(
  parameter int NET_WIDTH = 16
) (
  input  wire logic                          range_valid,
  output logic                               range_stall,
  input  wire logic [rtab_pkg::FIELD_W-1:0]  range_low,
  input  wire logic [rtab_pkg::FIELD_W-1:0]  range_high,
  output logic                               job_valid,
  input  wire logic                          job_stall,
  output logic [2*NET_WIDTH+1:0]             job_data
);
  import rtab_pkg::*;

  logic [NET_WIDTH-1:0] lo;
  logic [NET_WIDTH-1:0] hi;
  logic                 err;
  logic [NET_WIDTH:0]   count;

  // Reduce both ends to the network width, flag inverted ranges and
  // size the range as hi - lo + 1 (one bit wider, so a full space fits)
  always_comb begin
    lo    = NET_WIDTH'(range_low);
    hi    = NET_WIDTH'(range_high);
    err   = lo > hi;
    count = {1'b0, hi} - {1'b0, lo} + (NET_WIDTH+1)'(1);
    if (err) begin
      count = '0;
    end
  end

  assign job_valid   = range_valid;
  assign range_stall = job_stall;
  assign job_data    = {err, lo, count};

endmodule
`default_nettype wire

/* rtl/core/rtab_queue.sv */
`default_nettype none
module rtab_queue #(
  parameter int DATA_W = 34
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_stall,
  input  wire logic [DATA_W-1:0] push_data,
  output rtab_pkg::rtab_hs_t     pop_hs_valid,
  input  wire logic              pop_stall,
  output logic [DATA_W-1:0]      pop_data
);
  import rtab_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push;
  logic              pop;

  assign push_stall         = fill == CNT_W'(QUEUE_DEPTH);
  assign pop_hs_valid.valid = fill != '0;
  assign pop_hs_valid.stall = pop_stall;
  assign push               = push_valid && !push_stall;
  assign pop                = pop_hs_valid.valid && !pop_stall;
  assign pop_data           = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rtab_back.sv */
`default_nettype none
module rtab_back #(
  parameter int NET_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rtab_pkg::rtab_hs_t            job_hs,
  output logic                               job_stall,
  input  wire logic [2*NET_WIDTH+1:0]        job_data,
  output logic                               block_valid,
  input  wire logic                          block_stall,
  output logic [rtab_pkg::FIELD_W-1:0]       block_base,
  output logic [rtab_pkg::FIELD_W-1:0]       block_mask,
  output logic                               range_error,
  output logic                               last_block
);
  import rtab_pkg::*;

  logic                 busy;
  logic                 job_err;
  logic [NET_WIDTH:0]   cur;
  logic [NET_WIDTH:0]   remain;

  logic [NET_WIDTH:0]   align_mask;
  logic [NET_WIDTH:0]   smear;
  logic [NET_WIDTH:0]   span;
  logic [NET_WIDTH:0]   step;
  logic                 fin;
  logic                 advance;
  logic                 take;

  // Largest block aligned at cur that still fits in the remaining count:
  // alignment gives the ones below cur's lowest set bit, size gives the
  // ones below the leading one of the remaining count.
  always_comb begin
    align_mask = (cur - (NET_WIDTH+1)'(1)) & ~cur;
    smear      = remain;
    for (int s = 1; s < NET_WIDTH + 1; s = s * 2) begin
      smear = smear | (smear >> s);
    end
    span = align_mask & (smear >> 1);
    step = span + (NET_WIDTH+1)'(1);
    fin  = step == remain;
  end

  assign advance   = busy && (!block_valid || !block_stall);
  assign job_stall = busy;
  assign take      = job_hs.valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      block_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
      end else if (advance && (job_err || fin)) begin
        busy <= 1'b0;
      end
      if (advance) begin
        block_valid <= 1'b1;
      end else if (!block_stall) begin
        block_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_err <= job_data[2*NET_WIDTH+1];
      cur     <= {1'b0, job_data[2*NET_WIDTH:NET_WIDTH+1]};
      remain  <= job_data[NET_WIDTH:0];
    end else if (advance && !job_err) begin
      cur    <= cur + step;
      remain <= remain - step;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (job_err) begin
        block_base  <= '0;
        block_mask  <= '0;
        range_error <= 1'b1;
        last_block  <= 1'b1;
      end else begin
        block_base  <= FIELD_W'(cur);
        block_mask  <= FIELD_W'(~span[NET_WIDTH-1:0]);
        range_error <= 1'b0;
        last_block  <= fin;
      end
    end
  end

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    block_valid && range_error |-> last_block)
    else $error("error result not marked last");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    block_valid && range_error |-> block_base == '0 && block_mask == '0)
    else $error("error result carries a block");

  a_remain_live: assert property (@(posedge clk) disable iff (rst)
    busy && !job_err |-> remain != '0)
    else $error("generator busy with nothing left to cover");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && (job_err || fin) |=> !busy || $past(take))
    else $error("generator still busy after last block");
`endif

endmodule
`default_nettype wire

/* rtl/core/range_to_aligned_blocks_unit.sv */
`default_nettype none
// Channel   Direction  Handshake                  Payload
// range     in         range_valid / range_stall  range_low, range_high
// block     out        block_valid / block_stall  block_base, block_mask,
//                                                 range_error, last_block
//
// A range that splits into k blocks is loaded from the job queue into the
// block generator, which then yields one block per cycle while the block
// channel does not stall (k is at most 2*NET_WIDTH - 2, 30 for 16 bits).
// An inverted range yields one error transaction.
// The front classifies a range in the cycle it is accepted and parks it
// in a two-entry job queue, so up to two ranges wait behind the current one.
// Reset clears the queue, the generator and the output valid.
// A stall on the block channel freezes the generator and holds the result
// register; the range channel stalls only when the job queue is full.
module range_to_aligned_blocks_unit #(
  parameter int NET_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          range_valid,
  output logic                               range_stall,
  input  wire logic [rtab_pkg::FIELD_W-1:0]  range_low,
  input  wire logic [rtab_pkg::FIELD_W-1:0]  range_high,
  output logic                               block_valid,
  input  wire logic                          block_stall,
  output logic [rtab_pkg::FIELD_W-1:0]       block_base,
  output logic [rtab_pkg::FIELD_W-1:0]       block_mask,
  output logic                               range_error,
  output logic                               last_block
);
  import rtab_pkg::*;

  // Queue entry: error flag, range start, number count of the range
  localparam int JOB_W = 2 * NET_WIDTH + 2;

  logic             push_valid;
  logic             push_stall;
  logic [JOB_W-1:0] push_data;
  rtab_hs_t         job_hs;
  logic             job_stall;
  logic [JOB_W-1:0] job_data;

  // Front: accept a range transaction and classify it
  rtab_front #(
    .NET_WIDTH (NET_WIDTH)
  ) u_front (
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_low   (range_low),
    .range_high  (range_high),
    .job_valid   (push_valid),
    .job_stall   (push_stall),
    .job_data    (push_data)
  );

  // Decouple front and back so each side stalls on its own
  rtab_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_data    (push_data),
    .pop_hs_valid (job_hs),
    .pop_stall    (job_stall),
    .pop_data     (job_data)
  );

  // Back: walk the range one aligned block per cycle while the block channel does not stall
  rtab_back #(
    .NET_WIDTH (NET_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_hs      (job_hs),
    .job_stall   (job_stall),
    .job_data    (job_data),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .block_base  (block_base),
    .block_mask  (block_mask),
    .range_error (range_error),
    .last_block  (last_block)
  );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none
module tb_top;
  import rtab_pkg::*;

  localparam int NW          = 16;
  localparam int MAX_BLOCKS  = 30;
  localparam int RANDOM_PER_PHASE = 103;
  // Generator holds one range plus two queued ones, up to 30 blocks each
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLDOFF_CYCLES = 300;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] mask;
    logic               err;
    logic               last;
  } aligned_block_t;

  typedef struct packed {
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    bit                 typed;
    aligned_block_t     want;
  } range_row_t;

  localparam aligned_block_t NO_BLOCK = '{base: '0, mask: '0, err: 1'b0, last: 1'b0};
  localparam aligned_block_t ERR_BLOCK = '{base: '0, mask: '0, err: 1'b1, last: 1'b1};

  localparam int NUM_ROWS = 18;

  // Rows with typed results are single-block or error ranges; the rest go
  // through the block splitter below.
  range_row_t range_table [NUM_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'hFFFF, 1'b0, 1'b1}},
    '{16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b0, 1'b1}},
    '{16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}},
    '{16'h0001, 16'h0000, 1'b1, ERR_BLOCK},
    '{16'hFFFF, 16'h0000, 1'b1, ERR_BLOCK},
    '{16'h8000, 16'h7FFF, 1'b1, ERR_BLOCK},
    '{16'h0000, 16'h7FFF, 1'b1, '{16'h0000, 16'h8000, 1'b0, 1'b1}},
    '{16'h8000, 16'hFFFF, 1'b1, '{16'h8000, 16'h8000, 1'b0, 1'b1}},
    '{16'h0001, 16'hFFFE, 1'b0, NO_BLOCK},
    '{16'h0001, 16'hFFFF, 1'b0, NO_BLOCK},
    '{16'h0000, 16'hFFFE, 1'b0, NO_BLOCK},
    '{16'h0003, 16'h0004, 1'b0, NO_BLOCK},
    '{16'h5555, 16'hAAAA, 1'b0, NO_BLOCK},
    '{16'hAAAA, 16'h5555, 1'b1, ERR_BLOCK},
    '{16'h1234, 16'h5678, 1'b0, NO_BLOCK},
    '{16'hFFFE, 16'hFFFF, 1'b1, '{16'hFFFE, 16'hFFFE, 1'b0, 1'b1}},
    '{16'h7FFF, 16'h8000, 1'b0, NO_BLOCK},
    '{16'h0000, 16'h0001, 1'b1, '{16'h0000, 16'hFFFE, 1'b0, 1'b1}}
  };

  // Idling per phase, in percent of cycles
  int send_idle_tab [4] = '{0, 51, 0, 36};
  int recv_stall_tab [4] = '{0, 0, 51, 36};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               range_valid = 1'b0;
  logic               range_stall;
  logic [FIELD_W-1:0] range_low = '0;
  logic [FIELD_W-1:0] range_high = '0;
  logic               block_valid;
  logic               block_stall = 1'b0;
  logic [FIELD_W-1:0] block_base;
  logic [FIELD_W-1:0] block_mask;
  logic               range_error;
  logic               last_block;

  aligned_block_t pending_blocks [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit holdoff_req = 1'b0;
  int holdoff_left = 0;

  range_to_aligned_blocks_unit #(.NET_WIDTH(NW)) DUT (
    .clk         (clk),
    .rst         (rst),
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_low   (range_low),
    .range_high  (range_high),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .block_base  (block_base),
    .block_mask  (block_mask),
    .range_error (range_error),
    .last_block  (last_block)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // Walk a cursor one bit wider than a network number from lo up to hi,
  // taking the largest aligned block that still ends at or below hi; an inverted range gives one error block.
  function automatic void split_range(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
    logic [NW:0] cur;
    logic [NW:0] span;
    logic [NW:0] top;
    aligned_block_t blk;
    int count;
    top = {1'b0, hi[NW-1:0]};
    if (lo[NW-1:0] > hi[NW-1:0]) begin
      pending_blocks.push_back(ERR_BLOCK);
      return;
    end
    cur = {1'b0, lo[NW-1:0]};
    count = 0;
    while (cur <= top && count < MAX_BLOCKS) begin
      span = (NW+1)'(1);
      while ((cur & span) == '0 && (cur | span) <= top)
        span = (span << 1) | (NW+1)'(1);
      span = span >> 1;
      blk.base = cur[FIELD_W-1:0];
      blk.mask = FIELD_W'(~span[NW-1:0]);
      blk.err = 1'b0;
      count++;
      cur = (cur | span) + (NW+1)'(1);
      blk.last = (cur > top) || (count >= MAX_BLOCKS);
      pending_blocks.push_back(blk);
    end
  endfunction

  // Offer one range; entered and left just after a falling edge.
  task automatic send_range(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi,
                            bit typed, aligned_block_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      range_valid <= 1'b0;
      @(negedge clk);
    end
    range_valid <= 1'b1;
    range_low <= lo;
    range_high <= hi;
    @(posedge clk);
    while (range_stall) @(posedge clk);
    if (typed) pending_blocks.push_back(want);
    else split_range(lo, hi);
    @(negedge clk);
  endtask

  // Hold the sender until every expected block is out, then let the
  // generator settle before going on.
  task automatic wait_drained();
    range_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      block_stall <= 1'b1;
    end else begin
      block_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Compare each accepted block transaction with the oldest expectation.
  always @(posedge clk) begin : check_blocks
    aligned_block_t want;
    if (!rst && block_valid && !block_stall) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("block with no range pending", block_base, '0);
      end else begin
        want = pending_blocks.pop_front();
        if (block_base !== want.base) report_mismatch("block_base", block_base, want.base);
        if (block_mask !== want.mask) report_mismatch("block_mask", block_mask, want.mask);
        if (range_error !== want.err)
          report_mismatch("range_error", FIELD_W'(range_error), FIELD_W'(want.err));
        if (last_block !== want.last)
          report_mismatch("last_block", FIELD_W'(last_block), FIELD_W'(want.last));
      end
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    int kind;
    int k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ranges, no idling
    for (int i = 0; i < NUM_ROWS; i++)
      send_range(range_table[i].lo, range_table[i].hi, range_table[i].typed,
                 range_table[i].want);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tab[ph];
      recv_stall_pct = recv_stall_tab[ph];
      // Block the output for a long stretch so the job queue fills up
      if (ph == 0) holdoff_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        kind = $urandom_range(0, 9);
        lo = FIELD_W'($urandom);
        hi = FIELD_W'($urandom);
        case (kind)
          0, 1, 2, 3, 4: begin
            hi = lo + FIELD_W'($urandom_range(0, 32'hFFFF - lo));
          end
          5: begin
            hi = (lo > 16'hFFEB) ? 16'hFFFF : lo + FIELD_W'($urandom_range(0, 20));
          end
          6: begin
            if ($urandom_range(0, 1)) hi = 16'hFFFF;
            else lo = 16'h0000;
            if (lo > hi) hi = 16'hFFFF;
          end
          7: begin
            if (lo == '0) lo = 16'h0001;
            hi = FIELD_W'($urandom_range(0, lo - 1));
          end
          8: begin
          end
          default: begin
            // aligned block, sometimes nudged off by one at either end
            k = $urandom_range(0, NW);
            lo = lo & ~FIELD_W'((32'h1 << k) - 1);
            hi = lo | FIELD_W'((32'h1 << k) - 1);
            if ($urandom_range(0, 1) && lo != 16'hFFFF) lo = lo + FIELD_W'(1);
            if ($urandom_range(0, 1) && hi != lo) hi = hi - FIELD_W'(1);
          end
        endcase
        send_range(lo, hi, 1'b0, NO_BLOCK);
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/rtab_pkg.sv
rtl/core/rtab_front.sv
rtl/core/rtab_queue.sv
rtl/core/rtab_back.sv
rtl/core/range_to_aligned_blocks_unit.sv
dv/tb_top.sv
